### sv/ilid_pkg.sv
// Package for the indexed list block: sizes, opcodes, status codes and the
// command struct broadcast to the storage cells. No dependencies.
`default_nettype none
package ilid_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 7;
  localparam int OPC_W      = 3;
  localparam int OUTCNT_W   = 7;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [OPC_W-1:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_BEFORE = 3'd3,
    OP_DELETE = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

### sv/indexed_list_insert_delete.sv
// Indexed list with insert and delete: a row of ilid_cell entries that shift
// by one place per transaction. Uses ilid_pkg and ilid_cell.
// Result path: the reply is registered in stage s1, then in the output registers.
// Throughput: one transaction per cycle while in_stall is low; all cells shift in
// the accept cycle, and the read value goes through a two-level registered OR tree.
// Reset clears the entry count and the pipeline valids; cell contents are not reset.
`default_nettype none
module indexed_list_insert_delete (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ilid_pkg::OPC_W-1:0]         opcode,
  input  wire logic [ilid_pkg::POS_W-1:0]         position,
  input  wire logic signed [ilid_pkg::DATA_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ilid_pkg::DATA_W-1:0]      read_value,
  output logic [1:0]                              status,
  output logic [ilid_pkg::OUTCNT_W-1:0]           entry_count
);

  localparam int CAP  = ilid_pkg::CAPACITY;
  localparam int DW   = ilid_pkg::DATA_W;
  localparam int NG   = ilid_pkg::NUM_GROUPS;
  localparam int GS   = ilid_pkg::GROUP_SIZE;

  logic                        in_acc;
  logic                        s1_adv;
  logic [ilid_pkg::CNT_W-1:0]  count;
  logic [ilid_pkg::CNT_W-1:0]  count_next;
  logic [ilid_pkg::CMP_W-1:0]  pos_ext;
  logic [ilid_pkg::CMP_W-1:0]  cnt_ext;
  logic                        full;
  ilid_pkg::cell_cmd_t         cmd;
  ilid_pkg::status_t           st;
  logic                        ins_ok;
  logic                        del_ok;
  logic                        rd_ok;
  logic [ilid_pkg::IDX_W-1:0]  ins_idx;

  logic [DW-1:0] cell_data [CAP];
  logic [DW-1:0] cell_hit  [NG*GS];
  logic [DW-1:0] group_or  [NG];

  logic                        s1_valid;
  logic [DW-1:0]               s1_group [NG];
  ilid_pkg::status_t           s1_status;
  logic [ilid_pkg::CNT_W-1:0]  s1_count;
  logic [DW-1:0]               final_or;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign pos_ext = ilid_pkg::CMP_W'(position);
  assign cnt_ext = ilid_pkg::CMP_W'(count);
  assign full    = (count == ilid_pkg::CNT_W'(CAP));

  always_comb begin
    st      = ilid_pkg::ST_DONE;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    rd_ok   = 1'b0;
    ins_idx = '0;
    unique case (opcode)
      ilid_pkg::OP_READ: begin
        if (pos_ext < cnt_ext) rd_ok = 1'b1;
        else st = ilid_pkg::ST_RANGE;
      end
      ilid_pkg::OP_HEAD: begin
        if (full) st = ilid_pkg::ST_FULL;
        else ins_ok = 1'b1;
      end
      ilid_pkg::OP_TAIL: begin
        if (full) begin
          st = ilid_pkg::ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          ins_idx = count[ilid_pkg::IDX_W-1:0];
        end
      end
      ilid_pkg::OP_BEFORE: begin
        if (pos_ext > cnt_ext) begin
          st = ilid_pkg::ST_RANGE;
        end else if (full) begin
          st = ilid_pkg::ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          ins_idx = pos_ext[ilid_pkg::IDX_W-1:0];
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (pos_ext < cnt_ext) del_ok = 1'b1;
        else st = ilid_pkg::ST_RANGE;
      end
      default: st = ilid_pkg::ST_RANGE;
    endcase

    cmd.ins   = in_acc && ins_ok;
    cmd.del   = in_acc && del_ok;
    cmd.rd    = in_acc && rd_ok;
    cmd.idx   = ins_ok ? ins_idx : pos_ext[ilid_pkg::IDX_W-1:0];
    cmd.value = value;

    count_next = count;
    if (cmd.ins) count_next = count + 1'b1;
    else if (cmd.del) count_next = count - 1'b1;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      logic [DW-1:0] left_d;
      logic [DW-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAP - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      ilid_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cell_idx   (ilid_pkg::IDX_W'(gi)),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[gi]),
        .hit_data   (cell_hit[gi])
      );
    end
    for (gi = CAP; gi < NG*GS; gi++) begin : g_pad
      assign cell_hit[gi] = '0;
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < GS; k++) begin
        group_or[g] = group_or[g] | cell_hit[g*GS + k];
      end
    end
    final_or = '0;
    for (int g = 0; g < NG; g++) begin
      final_or = final_or | s1_group[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_group  <= group_or;
      s1_status <= st;
      s1_count  <= count_next;
    end
    if (s1_adv && s1_valid) begin
      read_value  <= final_or;
      status      <= s1_status;
      entry_count <= ilid_pkg::OUTCNT_W'(s1_count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ilid_pkg::CNT_W'(CAP))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not raise entry count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_status == ilid_pkg::ST_FULL |-> s1_count == ilid_pkg::CNT_W'(CAP))
    else $error("full status with list not full");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ilid_pkg::ST_DONE |-> read_value == '0)
    else $error("nonzero read value on failed transaction");

endmodule
`default_nettype wire

### sv/ilid_cell.sv
// One storage cell of the list: holds one entry, loads from its left or right
// neighbor on insert or delete, and drives its entry on a read hit. Uses ilid_pkg.
`default_nettype none
module ilid_cell (
  input  wire logic                          clk,
  input  wire ilid_pkg::cell_cmd_t           cmd,
  input  wire logic [ilid_pkg::IDX_W-1:0]    cell_idx,
  input  wire logic [ilid_pkg::DATA_W-1:0]   left_data,
  input  wire logic [ilid_pkg::DATA_W-1:0]   right_data,
  output logic      [ilid_pkg::DATA_W-1:0]   data,
  output logic      [ilid_pkg::DATA_W-1:0]   hit_data
);

  logic [ilid_pkg::DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (cell_idx > cmd.idx) begin
        data_next = left_data;
      end else if (cell_idx == cmd.idx) begin
        data_next = cmd.value;
      end
    end else if (cmd.del) begin
      if (cell_idx >= cmd.idx) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign hit_data = (cmd.rd && (cell_idx == cmd.idx)) ? data : '0;

endmodule
`default_nettype wire

### sim/indexed_list_insert_delete_tb.sv
// Self-checking testbench for indexed_list_insert_delete: a directed table, then random
// fill and drain runs checked against an in-bench list predictor.
// Depends on ilid_pkg and the indexed_list_insert_delete RTL.
module indexed_list_insert_delete_tb;

  localparam logic [ilid_pkg::OPC_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [ilid_pkg::OPC_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [ilid_pkg::OPC_W-1:0] OP_RSVD_HI  = 3'd7;

  localparam int DIR_N   = 25;
  localparam int TOTAL_N = DIR_N + 500;
  localparam int CALM_LO = 250;
  localparam int CALM_HI = 330;
  localparam int HOLD_AT = 120;
  localparam int HOLD_N  = 40;

  typedef struct packed {
    logic [ilid_pkg::OPC_W-1:0]  op;
    logic [ilid_pkg::POS_W-1:0]  pos;
    logic [ilid_pkg::DATA_W-1:0] val;
  } list_item_t;

  typedef struct packed {
    logic [ilid_pkg::DATA_W-1:0]   rd;
    ilid_pkg::status_t             st;
    logic [ilid_pkg::OUTCNT_W-1:0] cnt;
  } list_reply_t;

  typedef struct packed {
    logic [ilid_pkg::OPC_W-1:0]    op;
    logic [ilid_pkg::POS_W-1:0]    pos;
    logic [ilid_pkg::DATA_W-1:0]   val;
    logic                          chk;
    logic [ilid_pkg::DATA_W-1:0]   rd;
    ilid_pkg::status_t             st;
    logic [ilid_pkg::OUTCNT_W-1:0] cnt;
  } list_case_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [ilid_pkg::OPC_W-1:0]         opcode = '0;
  logic [ilid_pkg::POS_W-1:0]         position = '0;
  logic signed [ilid_pkg::DATA_W-1:0] value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [ilid_pkg::DATA_W-1:0] read_value;
  logic [1:0]                         status;
  logic [ilid_pkg::OUTCNT_W-1:0]      entry_count;

  indexed_list_insert_delete u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .status(status), .entry_count(entry_count)
  );

  // Directed rows start from an empty list; rows with chk set carry the
  // expected reply, the rest are checked against the predictor.
  list_case_t dir_tab [DIR_N] = '{
    '{ilid_pkg::OP_READ,   7'd0,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd0},
    '{ilid_pkg::OP_DELETE, 7'd0,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd0},
    '{ilid_pkg::OP_BEFORE, 7'd1,   32'h1234_5678, 1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd0},
    '{OP_RSVD_LO,          7'd0,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd0},
    '{ilid_pkg::OP_HEAD,   7'd0,   32'h7FFF_FFFF, 1'b1, 32'h0, ilid_pkg::ST_DONE,  7'd1},
    '{ilid_pkg::OP_TAIL,   7'd127, 32'h8000_0000, 1'b1, 32'h0, ilid_pkg::ST_DONE,  7'd2},
    '{ilid_pkg::OP_READ,   7'd0,   32'h0,  1'b1, 32'h7FFF_FFFF, ilid_pkg::ST_DONE, 7'd2},
    '{ilid_pkg::OP_READ,   7'd1,   32'hFFFF_FFFF,
      1'b1, 32'h8000_0000, ilid_pkg::ST_DONE, 7'd2},
    '{ilid_pkg::OP_BEFORE, 7'd0,   32'hFFFF_FFFF, 1'b1, 32'h0, ilid_pkg::ST_DONE,  7'd3},
    '{ilid_pkg::OP_BEFORE, 7'd3,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_DONE,  7'd4},
    '{ilid_pkg::OP_BEFORE, 7'd2,   32'h5555_5555, 1'b1, 32'h0, ilid_pkg::ST_DONE,  7'd5},
    '{ilid_pkg::OP_READ,   7'd127, 32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd5},
    '{ilid_pkg::OP_BEFORE, 7'd127, 32'hAAAA_AAAA, 1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd5},
    '{ilid_pkg::OP_DELETE, 7'd127, 32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd5},
    '{ilid_pkg::OP_READ,   7'd5,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd5},
    '{ilid_pkg::OP_DELETE, 7'd5,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd5},
    '{ilid_pkg::OP_BEFORE, 7'd6,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd5},
    '{ilid_pkg::OP_READ,   7'd2,   32'h0,         1'b0, 32'h0, ilid_pkg::ST_DONE,  7'd0},
    '{ilid_pkg::OP_READ,   7'd4,   32'h0,         1'b0, 32'h0, ilid_pkg::ST_DONE,  7'd0},
    '{ilid_pkg::OP_DELETE, 7'd0,   32'h0,         1'b0, 32'h0, ilid_pkg::ST_DONE,  7'd0},
    '{ilid_pkg::OP_DELETE, 7'd3,   32'h0,         1'b0, 32'h0, ilid_pkg::ST_DONE,  7'd0},
    '{ilid_pkg::OP_READ,   7'd0,   32'h0,         1'b0, 32'h0, ilid_pkg::ST_DONE,  7'd0},
    '{OP_RSVD_MID,         7'd0,   32'h0,         1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd3},
    '{OP_RSVD_HI,          7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0, ilid_pkg::ST_RANGE, 7'd3},
    '{ilid_pkg::OP_HEAD,   7'd0,   32'h1,         1'b0, 32'h0, ilid_pkg::ST_DONE,  7'd0}
  };

  logic signed [ilid_pkg::DATA_W-1:0] list_mirror [ilid_pkg::CAPACITY];
  int          list_len = 0;
  list_reply_t list_replies_q [$];

  int n_sent = 0;
  int n_got = 0;
  int n_err = 0;
  int n_full = 0;
  int n_range = 0;
  int peak_len = 0;
  bit filling = 1'b1;
  int mode_dwell = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic list_apply(input logic [ilid_pkg::OPC_W-1:0] op,
                            input logic [ilid_pkg::POS_W-1:0] pos,
                            input logic signed [ilid_pkg::DATA_W-1:0] val,
                            output list_reply_t r);
    int slot;
    int i;
    slot = -1;
    r.rd = '0;
    r.st = ilid_pkg::ST_DONE;
    case (op)
      ilid_pkg::OP_READ: begin
        if (int'(pos) < list_len) r.rd = list_mirror[pos[ilid_pkg::IDX_W-1:0]];
        else r.st = ilid_pkg::ST_RANGE;
      end
      ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL: begin
        if (list_len >= ilid_pkg::CAPACITY) r.st = ilid_pkg::ST_FULL;
        else slot = (op == ilid_pkg::OP_HEAD) ? 0 : list_len;
      end
      ilid_pkg::OP_BEFORE: begin
        if (int'(pos) > list_len) r.st = ilid_pkg::ST_RANGE;
        else if (list_len >= ilid_pkg::CAPACITY) r.st = ilid_pkg::ST_FULL;
        else slot = int'(pos);
      end
      ilid_pkg::OP_DELETE: begin
        if (int'(pos) < list_len) begin
          for (i = int'(pos); i < list_len - 1; i++)
            list_mirror[ilid_pkg::IDX_W'(i)] = list_mirror[ilid_pkg::IDX_W'(i + 1)];
          list_len--;
        end else begin
          r.st = ilid_pkg::ST_RANGE;
        end
      end
      default: r.st = ilid_pkg::ST_RANGE;
    endcase
    if (slot >= 0) begin
      for (i = list_len; i > slot; i--)
        list_mirror[ilid_pkg::IDX_W'(i)] = list_mirror[ilid_pkg::IDX_W'(i - 1)];
      list_mirror[ilid_pkg::IDX_W'(slot)] = val;
      list_len++;
    end
    if (r.st == ilid_pkg::ST_FULL) n_full++;
    if (r.st == ilid_pkg::ST_RANGE) n_range++;
    if (list_len > peak_len) peak_len = list_len;
    r.cnt = list_len[ilid_pkg::OUTCNT_W-1:0];
  endtask

  // Alternates fill and drain runs so the list reaches both full and empty,
  // dwelling a few transactions at each end.
  function automatic list_item_t pick_list_item();
    list_item_t it;
    int roll;
    if ((filling && list_len == ilid_pkg::CAPACITY) || (!filling && list_len == 0)) begin
      mode_dwell++;
      if (mode_dwell > 6) begin
        filling = !filling;
        mode_dwell = 0;
      end
    end
    roll = $urandom_range(99);
    if (roll < 5) it.op = ilid_pkg::OPC_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    else if (filling) begin
      if (roll < 25) it.op = ilid_pkg::OP_HEAD;
      else if (roll < 45) it.op = ilid_pkg::OP_TAIL;
      else if (roll < 75) it.op = ilid_pkg::OP_BEFORE;
      else if (roll < 88) it.op = ilid_pkg::OP_READ;
      else it.op = ilid_pkg::OP_DELETE;
    end else begin
      if (roll < 55) it.op = ilid_pkg::OP_DELETE;
      else if (roll < 75) it.op = ilid_pkg::OP_READ;
      else if (roll < 85) it.op = ilid_pkg::OP_HEAD;
      else if (roll < 90) it.op = ilid_pkg::OP_TAIL;
      else it.op = ilid_pkg::OP_BEFORE;
    end
    if ($urandom_range(99) < 12) it.pos = ilid_pkg::POS_W'($urandom_range(127));
    else if (it.op == ilid_pkg::OP_BEFORE)
      it.pos = ilid_pkg::POS_W'($urandom_range(list_len));
    else
      it.pos = (list_len == 0) ? '0 : ilid_pkg::POS_W'($urandom_range(list_len - 1));
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0: it.val = 32'h8000_0000;
        1: it.val = 32'h7FFF_FFFF;
        2: it.val = '1;
        default: it.val = '0;
      endcase
    end else begin
      it.val = $urandom();
    end
    return it;
  endfunction

  // Sender: predicts each accepted transaction, then offers the next one or idles.
  always @(posedge clk) begin
    list_reply_t r;
    list_item_t nx;
    int k;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      k = n_sent;
      if (in_valid && !in_stall) begin
        list_apply(opcode, position, value, r);
        if (k < DIR_N && dir_tab[k].chk) begin
          r.rd = dir_tab[k].rd;
          r.st = dir_tab[k].st;
          r.cnt = dir_tab[k].cnt;
        end
        list_replies_q.push_back(r);
        k++;
        n_sent <= k;
      end
      if (!in_valid || !in_stall) begin
        if (k >= TOTAL_N || (!(k >= CALM_LO && k < CALM_HI) && $urandom_range(99) < 29)) begin
          in_valid <= 1'b0;
        end else begin
          if (k < DIR_N) begin
            nx.op = dir_tab[k].op;
            nx.pos = dir_tab[k].pos;
            nx.val = dir_tab[k].val;
          end else begin
            nx = pick_list_item();
          end
          in_valid <= 1'b1;
          opcode <= nx.op;
          position <= nx.pos;
          value <= nx.val;
        end
      end
    end
  end

  // Receiver: checks each reply against the oldest expectation; holds off
  // once for a long stretch so the block backs up.
  always @(posedge clk) begin
    list_reply_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_got <= n_got + 1;
        if (list_replies_q.size() == 0) begin
          if (n_err < 10) $display("unexpected reply: rd=%h st=%0d cnt=%0d",
                                   read_value, status, entry_count);
          n_err <= n_err + 1;
        end else begin
          e = list_replies_q.pop_front();
          if (read_value !== e.rd || status !== e.st || entry_count !== e.cnt) begin
            if (n_err < 10)
              $display("reply %0d mismatch: rd %h/%h st %0d/%0d cnt %0d/%0d (exp/act)",
                       n_got, e.rd, read_value, e.st, status, e.cnt, entry_count);
            n_err <= n_err + 1;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!held_once && n_got >= HOLD_AT) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_N;
        held_once <= 1'b1;
      end else if (n_got >= CALM_LO && n_got < CALM_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 29);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (n_sent < TOTAL_N || list_replies_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d list transactions, %0d replies: %0d refused full, %0d out of range",
             n_sent, n_got, n_full, n_range);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_len, ilid_pkg::CAPACITY,
             n_err);
    if (n_err == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d sent, %0d replies outstanding", n_sent, list_replies_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
